@@ sv/hrv_pkg.sv @@
// Shared types, constants and helper functions of the reset vector relocator.
package hrv_pkg;

  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [9:0] POS_MAX    = 10'd1023;
  localparam logic [9:0] DATA_START = 10'd9;
  localparam logic [7:0] RJMP_OP    = 8'hC0;
  localparam logic [7:0] VEC_MASK   = 8'hFE;

  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_VECTOR_BYTE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LOADER_ADDR = 1'd1;

  // One classified character as it travels from front to back.
  typedef struct packed {
    logic [7:0] ch;
    logic [9:0] pos;
    logic [3:0] nib;
    logic       is_lf;
  } word_t;

  // Configuration seen by the back end.
  typedef struct packed {
    logic [7:0]  vector_byte;
    logic [15:0] loader_address;
    logic        jump_load;
    logic [15:0] jump_value;
  } cfg_t;

  function automatic logic [3:0] nib_of(input logic [7:0] c);
    logic [3:0] n;
    n = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) n = 4'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) n = 4'(c - 8'h37);
    else if (c >= 8'h61 && c <= 8'h66) n = 4'(c - 8'h57);
    return n;
  endfunction

  function automatic logic [7:0] hex_up(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) c = 8'h30 + {4'd0, n};
    else c = 8'h37 + {4'd0, n};
    return c;
  endfunction

endpackage

@@ sv/hrv_in_if.sv @@
// Input character channel.
interface hrv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;

  modport source (output valid, output in_char, input ready);
  modport sink (input valid, input in_char, output ready);
endinterface

@@ sv/hrv_out_if.sv @@
// Output character channel.
interface hrv_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;

  modport source (output valid, output out_char, input ready);
  modport sink (input valid, input out_char, output ready);
endinterface

@@ sv/hrv_front.sv @@
// Front end: accept characters, track line position and decode hex digits.
module hrv_front
  import hrv_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  hrv_in_if.sink rx,
  input  logic   q_ready,
  output logic   q_push,
  output word_t  q_word
);

  logic [9:0] line_pos;
  logic       is_lf;

  assign is_lf    = (rx.in_char == CHAR_LF);
  assign rx.ready = q_ready;
  assign q_push   = rx.valid && q_ready;

  assign q_word.ch    = rx.in_char;
  assign q_word.pos   = line_pos;
  assign q_word.nib   = nib_of(rx.in_char);
  assign q_word.is_lf = is_lf;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_pos <= '0;
    end else if (q_push) begin
      // restart on line feed, saturate on overlong lines
      if (is_lf) line_pos <= '0;
      else if (line_pos != POS_MAX) line_pos <= line_pos + 10'd1;
    end
  end

endmodule

@@ sv/hrv_queue.sv @@
// Two-entry queue between front and back end.
module hrv_queue
  import hrv_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  word_t push_word,
  output logic  push_ready,
  input  logic  pop,
  output logic  pop_valid,
  output word_t pop_word
);

  word_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_word   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

@@ sv/hrv_back.sv @@
// Back end: parse record header, patch data bytes and checksum, drive output.
module hrv_back
  import hrv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       q_valid,
  input  word_t      q_word,
  output logic       q_pop,
  hrv_out_if.source  tx
);

  logic [7:0]  rec_count, rec_count_next;
  logic [15:0] rec_addr, rec_addr_next;
  logic [7:0]  rec_kind, rec_kind_next;
  logic [7:0]  run_sum, run_sum_next;
  logic [3:0]  digit_hold, digit_hold_next;
  logic        reset_rec, reset_rec_next;
  logic        vec_hit, vec_hit_next;
  logic [7:0]  vec_offset, vec_offset_next;
  logic        rec_patched, rec_patched_next;
  logic [15:0] saved_jump, saved_jump_next;
  logic [7:0]  low_hold, low_hold_next;

  logic        take;
  logic [7:0]  o;
  logic [7:0]  b;
  logic [9:0]  d;
  logic [8:0]  k;
  logic        half;
  logic [15:0] v;
  logic [15:0] v_diff;
  logic [15:0] w;
  logic [15:0] sj_sub;
  logic        rep;
  logic [7:0]  r;
  logic [7:0]  neg_sum;

  assign take  = q_valid && (!tx.valid || tx.ready);
  assign q_pop = take;

  always_comb begin
    rec_count_next   = rec_count;
    rec_addr_next    = rec_addr;
    rec_kind_next    = rec_kind;
    run_sum_next     = run_sum;
    digit_hold_next  = digit_hold;
    reset_rec_next   = reset_rec;
    vec_hit_next     = vec_hit;
    vec_offset_next  = vec_offset;
    rec_patched_next = rec_patched;
    saved_jump_next  = saved_jump;
    low_hold_next    = low_hold;
    o       = q_word.ch;
    b       = {digit_hold, q_word.nib};
    d       = q_word.pos - DATA_START;
    k       = d[9:1];
    half    = d[0];
    v       = {8'd0, cfg.vector_byte & VEC_MASK};
    v_diff  = v - rec_addr;
    w       = {1'b0, cfg.loader_address[15:1]} - 16'd1;
    sj_sub  = saved_jump - {9'd0, cfg.vector_byte[7:1]};
    rep     = 1'b0;
    r       = 8'd0;
    neg_sum = 8'd0 - run_sum;

    if (q_word.is_lf) begin
      reset_rec_next   = 1'b0;
      vec_hit_next     = 1'b0;
      rec_patched_next = 1'b0;
    end else if (q_word.pos >= 10'd1 && q_word.pos <= 10'd8) begin
      if (q_word.pos[0]) begin
        digit_hold_next = q_word.nib;
        if (q_word.pos == 10'd1) run_sum_next = 8'd0;
      end else begin
        run_sum_next = run_sum + b;
        case (q_word.pos[2:1])
          2'd1: rec_count_next = b;
          2'd2: rec_addr_next = {b, 8'd0};
          2'd3: rec_addr_next = {rec_addr[15:8], b};
          default: begin
            // record type: classify the record once
            rec_kind_next  = b;
            reset_rec_next = (cfg.vector_byte != 8'd0) && (rec_addr == 16'd0) &&
                             (b == 8'd0) && (rec_count >= 8'd2);
            vec_hit_next   = (cfg.vector_byte != 8'd0) && (v != 16'd0) && (b == 8'd0) &&
                             (rec_count != 8'd0) && (v >= rec_addr) &&
                             (v_diff < {8'd0, rec_count});
            vec_offset_next  = vec_hit_next ? v_diff[7:0] : 8'd0;
            rec_patched_next = reset_rec_next || vec_hit_next;
          end
        endcase
      end
    end else if (q_word.pos >= DATA_START) begin
      if (k < {1'b0, rec_count}) begin
        if (reset_rec && k <= 9'd1) begin
          rep = 1'b1;
          r   = (k == 9'd0) ? w[7:0] : (RJMP_OP | {4'd0, w[11:8]});
        end else if (vec_hit && k == {1'b0, vec_offset}) begin
          rep = 1'b1;
          if (!half) begin
            saved_jump_next = sj_sub;
            r = sj_sub[7:0];
          end else begin
            r = saved_jump[7:0];
          end
        end else if (vec_hit && k == {1'b0, vec_offset} + 9'd1) begin
          rep = 1'b1;
          r   = RJMP_OP | {4'd0, saved_jump[11:8]};
        end
        if (!half) begin
          digit_hold_next = q_word.nib;
        end else begin
          if (reset_rec && k == 9'd0) low_hold_next = b;
          if (reset_rec && k == 9'd1) saved_jump_next = {4'd0, b[3:0], low_hold};
          run_sum_next = run_sum + (rep ? r : b);
        end
        if (rep) o = hex_up(half ? r[3:0] : r[7:4]);
      end else if (k == {1'b0, rec_count} && rec_patched) begin
        o = hex_up(half ? neg_sum[3:0] : neg_sum[7:4]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_count   <= '0;
      rec_addr    <= '0;
      rec_kind    <= '0;
      run_sum     <= '0;
      digit_hold  <= '0;
      reset_rec   <= 1'b0;
      vec_hit     <= 1'b0;
      vec_offset  <= '0;
      rec_patched <= 1'b0;
      saved_jump  <= '0;
      low_hold    <= '0;
      tx.valid    <= 1'b0;
    end else begin
      if (take) begin
        rec_count   <= rec_count_next;
        rec_addr    <= rec_addr_next;
        rec_kind    <= rec_kind_next;
        run_sum     <= run_sum_next;
        digit_hold  <= digit_hold_next;
        reset_rec   <= reset_rec_next;
        vec_hit     <= vec_hit_next;
        vec_offset  <= vec_offset_next;
        rec_patched <= rec_patched_next;
        low_hold    <= low_hold_next;
        tx.valid    <= 1'b1;
      end else if (tx.ready) begin
        tx.valid <= 1'b0;
      end
      if (cfg.jump_load) saved_jump <= cfg.jump_value;
      else if (take) saved_jump <= saved_jump_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) tx.out_char <= o;
  end

endmodule

@@ sv/hex_reset_vector_relocator.sv @@
// Top level of the Intel HEX reset vector relocator.
// A word accepted on rx is written into the queue, then taken by the back end into the
// output register, which presents it on tx.
// Throughput: one word per cycle unless tx stalls; the record parser is combinational.
// The two-entry queue and the output register hold up to three words; rx.ready drops only
// once all three are full, i.e. at most two words after tx stalls.
// Reset (rst, synchronous, active high) clears line position, record state,
// the saved jump and both configuration registers.
module hex_reset_vector_relocator
  import hrv_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  hrv_in_if.sink                 rx,
  hrv_out_if.source              tx,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [7:0]  vector_byte;
  logic [15:0] loader_address;
  cfg_t        cfg;

  logic        f_push;
  word_t       f_word;
  logic        q_ready;
  logic        q_valid;
  word_t       q_word;
  logic        q_pop;

  // Configuration registers; a loader address write also preloads the saved jump.
  always_ff @(posedge clk) begin
    if (rst) begin
      vector_byte    <= '0;
      loader_address <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VECTOR_BYTE: vector_byte    <= cfg_data[7:0];
        REG_LOADER_ADDR: loader_address <= cfg_data;
        default:         vector_byte    <= vector_byte;
      endcase
    end
  end

  assign cfg.vector_byte    = vector_byte;
  assign cfg.loader_address = loader_address;
  assign cfg.jump_load      = cfg_we && (cfg_index == REG_LOADER_ADDR);
  assign cfg.jump_value     = cfg_data;

  // Front: count line position and decode the hex digit of each word.
  hrv_front u_front (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx),
    .q_ready (q_ready),
    .q_push  (f_push),
    .q_word  (f_word)
  );

  // Short queue: lets the front keep accepting while the back waits on tx.
  hrv_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (f_push),
    .push_word  (f_word),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_word   (q_word)
  );

  // Back: parse the record, substitute jump bytes and checksum, hold the output word.
  hrv_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_word  (q_word),
    .q_pop   (q_pop),
    .tx      (tx)
  );

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for the HEX reset vector relocator: directed and random records.
`timescale 1ns / 1ps

class hex_patch_board;
  bit [7:0]  vec_byte;
  bit [15:0] loader;
  bit [9:0]  pos;
  bit [7:0]  count;
  bit [15:0] addr;
  bit [7:0]  kind;
  bit [7:0]  sum;
  bit [3:0]  hold;
  bit        boot_rec;
  bit        hit;
  bit [7:0]  hit_off;
  bit        patched;
  bit [15:0] jump;
  bit [7:0]  low_byte;
  bit [7:0]  patched_text[$];
  int        errors;

  function void write_reg(bit [hrv_pkg::CFG_INDEX_W-1:0] index, bit [15:0] value);
    if (index == hrv_pkg::REG_VECTOR_BYTE) begin
      vec_byte = value[7:0];
    end else begin
      loader = value;
      jump = value;
    end
  endfunction

  function bit [3:0] nibble(bit [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return 4'(c - 8'h30);
    if (c >= 8'h41 && c <= 8'h46) return 4'(c - 8'h37);
    if (c >= 8'h61 && c <= 8'h66) return 4'(c - 8'h57);
    return 4'h0;
  endfunction

  function bit [7:0] ascii_hex(bit [3:0] n);
    return (n < 4'd10) ? 8'h30 + {4'h0, n} : 8'h37 + {4'h0, n};
  endfunction

  // Byte that replaces data byte k, if any; the saved jump moves on the first digit.
  function bit substitute(int k, bit first, output bit [7:0] r);
    bit [15:0] w;
    r = 8'h00;
    if (boot_rec && k <= 1) begin
      w = (loader >> 1) - 16'd1;
      r = (k == 0) ? w[7:0] : {4'hC, w[11:8]};
      return 1'b1;
    end
    if (hit && k == hit_off) begin
      if (first) jump = jump - {9'h000, vec_byte[7:1]};
      r = jump[7:0];
      return 1'b1;
    end
    if (hit && k == hit_off + 1) begin
      r = {4'hC, jump[11:8]};
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function void take_char(bit [7:0] c);
    bit [7:0]  o, b, r;
    bit [3:0]  nib;
    bit [15:0] v;
    int        p, k;
    bit        second, rep;
    o = c;
    p = pos;
    if (c == hrv_pkg::CHAR_LF) begin
      pos = 10'd0;
      boot_rec = 1'b0;
      hit = 1'b0;
      patched = 1'b0;
      patched_text.push_back(c);
      return;
    end
    pos = (p < 1023) ? 10'(p + 1) : 10'd1023;
    nib = nibble(c);
    if (p >= 1 && p <= 8) begin
      if ((p & 1) != 0) begin
        hold = nib;
        if (p == 1) sum = 8'h00;
      end else begin
        b = {hold, nib};
        sum = sum + b;
        case (p)
          2: count = b;
          4: addr = {b, 8'h00};
          6: addr = addr | {8'h00, b};
          default: begin
            v = {8'h00, vec_byte & 8'hFE};
            kind = b;
            boot_rec = vec_byte != 0 && addr == 0 && kind == 0 && count >= 2;
            hit = vec_byte != 0 && v != 0 && kind == 0 && count != 0 && v >= addr &&
                  (v - addr) < {8'h00, count};
            hit_off = hit ? 8'(v - addr) : 8'h00;
            patched = boot_rec || hit;
          end
        endcase
      end
    end else if (p >= 9) begin
      k = (p - 9) >> 1;
      second = ((p - 9) & 1) != 0;
      if (k < count) begin
        rep = substitute(k, !second, r);
        if (!second) begin
          hold = nib;
        end else begin
          b = {hold, nib};
          if (boot_rec && k == 0) low_byte = b;
          if (boot_rec && k == 1) jump = {4'h0, b[3:0], low_byte};
          sum = sum + (rep ? r : b);
        end
        if (rep) o = ascii_hex(second ? r[3:0] : r[7:4]);
      end else if (k == count && patched) begin
        b = -sum;
        o = ascii_hex(second ? b[3:0] : b[7:4]);
      end
    end
    patched_text.push_back(o);
  endfunction

  function void check_char(logic [7:0] got);
    bit [7:0] want;
    if (patched_text.size() == 0) begin
      $display("%0t: out_char 0x%02h arrived, expected nothing", $time, got);
      errors++;
      return;
    end
    want = patched_text.pop_front();
    if (got !== want) begin
      $display("%0t: out_char mismatch, expected 0x%02h, actual 0x%02h", $time, want, got);
      errors++;
    end
  endfunction

  function int pending();
    return patched_text.size();
  endfunction
endclass

module tb_top;
  import hrv_pkg::*;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  hrv_in_if  rx_ch();
  hrv_out_if tx_ch();

  hex_reset_vector_relocator uut (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx_ch),
    .tx        (tx_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  hex_patch_board board = new();

  int sent;          // words accepted on rx
  int got_words;     // words accepted on tx
  bit calm;          // no idling on either side once set
  int gap_odds;      // sender idles about once in gap_odds+1 words; 0 means never
  bit lower_digits;  // current record written in lower-case hex
  int spoil_at;      // digit of the current record to replace by junk, -1 for none
  int digit_no;

  // 20 ns period
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Offer one word, idling first now and then, and hold it until the block takes it.
  task automatic send_char(input logic [7:0] c);
    if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
      rx_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    rx_ch.valid <= 1'b1;
    rx_ch.in_char <= c;
    do @(posedge clk); while (!rx_ch.ready);
    board.take_char(c);
    sent++;
  endtask

  // One hex digit of a record, in the case of the record, or junk where spoilt.
  task automatic put_digit(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) c = 8'h30 + {4'h0, n};
    else c = (lower_digits ? 8'h57 : 8'h37) + {4'h0, n};
    if (digit_no == spoil_at) begin
      // characters just outside the hex ranges, plus the ends of the byte range
      case ($urandom_range(0, 7))
        0: c = 8'h2F;
        1: c = 8'h3A;
        2: c = 8'h40;
        3: c = 8'h47;
        4: c = 8'h60;
        5: c = 8'h67;
        6: c = 8'h00;
        default: c = 8'hFF;
      endcase
    end
    digit_no++;
    send_char(c);
  endtask

  task automatic put_byte(input logic [7:0] b);
    put_digit(b[7:4]);
    put_digit(b[3:0]);
  endtask

  // Send a whole record line with random data; tail words follow the checksum.
  task automatic send_record(input logic [7:0] n, input logic [15:0] at,
                             input logic [7:0] kind, input int spoil, input int tail);
    logic [7:0] sum, d, check;
    digit_no = 0;
    spoil_at = spoil;
    lower_digits = $urandom_range(0, 3) == 0;
    send_char(CHAR_COLON);
    put_byte(n);
    put_byte(at[15:8]);
    put_byte(at[7:0]);
    put_byte(kind);
    sum = n + at[15:8] + at[7:0] + kind;
    for (int i = 0; i < n; i++) begin
      d = 8'($urandom);
      sum = sum + d;
      put_byte(d);
    end
    // a wrong checksum now and then: the block must not care
    check = -sum;
    if ($urandom_range(0, 15) == 0) check = 8'($urandom);
    put_byte(check);
    for (int i = 0; i < tail; i++) send_char(8'($urandom_range(8'h20, 8'h7E)));
    if ($urandom_range(0, 3) == 0) send_char(CHAR_CR);
    send_char(CHAR_LF);
  endtask

  // Drop valid and hold until every expected word has come back.
  task automatic wait_drained();
    rx_ch.valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  // Write both registers while the block is empty.
  task automatic set_config(input logic [7:0] vb, input logic [15:0] la);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= REG_VECTOR_BYTE;
    cfg_data <= {8'h00, vb};
    @(posedge clk);
    cfg_index <= REG_LOADER_ADDR;
    cfg_data <= la;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.write_reg(REG_VECTOR_BYTE, {8'h00, vb});
    board.write_reg(REG_LOADER_ADDR, la);
  endtask

  // Mostly well-formed records aimed at the reset word and the vector, some noise.
  task automatic send_random_line();
    logic [7:0]  n, vec;
    logic [15:0] at;
    int          pick, spoil, tail;
    vec = board.vec_byte & 8'hFE;
    case ($urandom_range(0, 2))
      0: gap_odds = 0;
      1: gap_odds = 2;
      default: gap_odds = 7;
    endcase
    tail = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : 0;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      n = 8'($urandom_range(0, 8));
      at = 16'h0000;
    end else if (pick < 60) begin
      // place the vector anywhere in the record, on its last byte, or just past it
      n = 8'($urandom_range(0, 12));
      at = {8'h00, vec} - 16'($urandom_range(0, n));
    end else if (pick < 72) begin
      n = 8'($urandom_range(0, 8));
      at = ($urandom_range(0, 1) == 0) ? 16'h0000 : {8'h00, vec};
    end else if (pick < 86) begin
      n = 8'($urandom_range(0, 16));
      at = 16'($urandom);
    end else if (pick < 88) begin
      n = 8'($urandom_range(200, 255));
      at = 16'($urandom_range(0, 2));
    end else begin
      // raw noise, any byte value, line feeds included
      for (int i = $urandom_range(0, 24); i > 0; i--) send_char(8'($urandom));
      send_char(CHAR_LF);
      return;
    end
    spoil = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 9 + 2 * n) : -1;
    if (pick >= 60 && pick < 72) begin
      case ($urandom_range(0, 3))
        0: send_record(n, at, 8'h01, spoil, tail);
        1: send_record(n, at, 8'h02, spoil, tail);
        2: send_record(n, at, 8'h04, spoil, tail);
        default: send_record(n, at, 8'($urandom), spoil, tail);
      endcase
    end else begin
      send_record(n, at, 8'h00, spoil, tail);
    end
  endtask

  task automatic random_phase(input logic [7:0] vb, input logic [15:0] la, input int words);
    int start;
    set_config(vb, la);
    start = sent;
    while (sent - start < words) send_random_line();
  endtask

  // Receiver: check every word taken, stall in bursts, and once for a long stretch
  // while the sender is still busy so that the block fills and pushes back on rx.
  initial begin
    int stall_left;
    int sink_odds;
    int cyc;
    bit long_hold_done;
    tx_ch.ready = 1'b0;
    got_words = 0;
    stall_left = 0;
    sink_odds = 0;
    cyc = 0;
    long_hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && tx_ch.valid && tx_ch.ready) begin
        board.check_char(tx_ch.out_char);
        got_words++;
      end
      cyc++;
      if (cyc % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: sink_odds = 0;
          1: sink_odds = 3;
          default: sink_odds = 9;
        endcase
      end
      if (stall_left > 0) begin
        stall_left--;
        tx_ch.ready <= 1'b0;
      end else if (!long_hold_done && got_words >= 400 && rx_ch.valid) begin
        long_hold_done = 1'b1;
        stall_left = 63;
        tx_ch.ready <= 1'b0;
      end else if (!calm && sink_odds != 0 && $urandom_range(0, sink_odds) == 0) begin
        stall_left = $urandom_range(0, 7);
        tx_ch.ready <= 1'b0;
      end else begin
        tx_ch.ready <= 1'b1;
      end
    end
  end

  // Stimulus
  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rx_ch.valid = 1'b0;
    rx_ch.in_char = 8'h00;
    sent = 0;
    calm = 1'b0;
    gap_odds = 4;
    spoil_at = -1;
    digit_no = 0;
    lower_digits = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Pass-through: a reset record must come back untouched, as must odd bytes.
    set_config(8'h00, 16'hFFFF);
    send_record(8'h02, 16'h0000, 8'h00, -1, 0);
    send_char(8'h00);
    send_char(8'hFF);
    send_char(CHAR_LF);

    set_config(8'h08, 16'h7E00);
    send_record(8'h10, 16'h0000, 8'h00, -1, 0);  // reset word and vector in one record
    send_record(8'h05, 16'h0004, 8'h00, -1, 0);  // vector on the last data byte
    send_record(8'h02, 16'h0008, 8'h00, -1, 0);  // hit again: distance taken off once more
    send_record(8'h00, 16'h0008, 8'h00, -1, 0);  // zero count never matches
    send_record(8'h01, 16'h0000, 8'h00, -1, 0);  // too short to be the reset record
    send_record(8'h02, 16'h0008, 8'h00, 9, 0);   // junk digit in the first data byte
    send_record(8'h00, 16'h0000, 8'h01, -1, 0);  // end of file

    // Random part across several settings, the extremes among them.
    random_phase(8'h01, 16'($urandom), 20);     // vector word zero: only the reset word
    random_phase(8'hFE, 16'hFFFF, 30);
    random_phase(8'h02, 16'h0000, 20);
    random_phase(8'($urandom_range(0, 126) * 2 + 1), 16'($urandom), 20);  // odd vector
    random_phase(8'($urandom_range(1, 127) * 2), 16'($urandom), 30);
    random_phase(8'h00, 16'($urandom), 20);

    // Overlong line: the position must saturate, not wrap back into the header.
    set_config(8'h20, 16'h1F00);
    send_record(8'h02, 16'h0000, 8'h00, -1, 1016);
    send_record(8'h04, 16'h001E, 8'h00, -1, 0);

    // Closing stretch at full rate on both sides.
    calm = 1'b1;
    random_phase(8'($urandom_range(1, 127) * 2), 16'($urandom), 30);

    wait_drained();
    repeat (4) @(posedge clk);
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #10000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
